@@ sv/assert_macros.svh @@
// Assertion helpers shared by rbd_ctrl and ring_buffer_deque.
// Both expect clock aclk and active-low synchronous reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rbd_pkg.sv @@
`timescale 1ns / 1ps
package rbd_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;   // width of the count field on the result port

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } rbd_cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } rbd_status_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } rbd_mem_req_t;

    typedef struct packed {
        logic               has_data;
        rbd_status_t        status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } rbd_res_t;

endpackage

@@ sv/rbd_ram.sv @@
`timescale 1ns / 1ps
module rbd_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // rdata holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rbd_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [2:0]         cmd,
    input  logic [DATA_W-1:0]  value,
    output rbd_mem_req_t       mem_req,
    output rbd_res_t           res
);

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              empty, full;
    logic [ADDR_W-1:0] head_prev, head_succ, tail_slot, last_slot;
    logic [SUM_W-1:0]  sum;
    rbd_cmd_t          op;

    assign op    = rbd_cmd_t'(cmd);
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_W'(CAPACITY));

    assign head_prev = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_succ = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // first free slot past the back; sum stays below twice the capacity
    assign sum       = SUM_W'(head_reg) + SUM_W'(cnt_reg);
    assign tail_slot = (sum >= SUM_W'(CAPACITY)) ? ADDR_W'(sum - SUM_W'(CAPACITY))
                                                 : ADDR_W'(sum);
    assign last_slot = (tail_slot == '0) ? ADDR_W'(CAPACITY - 1) : tail_slot - 1'b1;

    always_comb begin
        head_next        = head_reg;
        cnt_next         = cnt_reg;
        mem_req.we       = 1'b0;
        mem_req.re       = 1'b0;
        mem_req.addr     = head_reg;
        mem_req.wdata    = value;
        res.has_data     = 1'b0;
        res.status       = ST_OK;
        case (op)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    mem_req.we   = accept;
                    mem_req.addr = head_prev;
                    head_next    = head_prev;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    mem_req.we   = accept;
                    mem_req.addr = tail_slot;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    mem_req.re   = accept;
                    res.has_data = 1'b1;
                    if (op == CMD_POP_FRONT) begin
                        head_next = head_succ;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    mem_req.re   = accept;
                    mem_req.addr = last_slot;
                    res.has_data = 1'b1;
                    if (op == CMD_POP_BACK) begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.count    = COUNT_W'(cnt_next);
        res.is_empty = (cnt_next == '0);
        res.is_full  = (cnt_next == CNT_W'(CAPACITY));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end else if (accept) begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(CAPACITY), "item count beyond capacity")
    `ASSERT_ALWAYS(a_head_range, head_reg <= ADDR_W'(CAPACITY - 1), "head slot out of range")
    `ASSERT_NEXT(a_push_grows, aresetn && accept && mem_req.we,
                 cnt_reg == $past(cnt_reg) + 1'b1, "push did not grow the count")

endmodule

@@ sv/ring_buffer_deque.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Ports                      Word
// s_        in   s_tvalid s_tready s_tdata  cmd, value
// m_        out  m_tvalid m_tready m_tdata  data, status, count, is_empty, is_full
//
// One word per cycle unless stalled; a result is valid the cycle after its word.
// The store is a single-port synchronous RAM: per command, at most one read or write.
// Reset (aresetn low, synchronous) empties the deque; the store is not cleared.
// While a result waits on m_tready low, s_tready drops; no word is lost or repeated.
`include "assert_macros.svh"
module ring_buffer_deque
    import rbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [2:0] cmd, [34:3] value, [39:35] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // [31:0] data, [33:32] status, [44:34] count,
                                    // [45] is_empty, [46] is_full, [47] zero
);

    logic              s_accept;
    rbd_mem_req_t      mem_req;
    rbd_res_t          res, res_reg;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] rdata;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    rbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .cmd     (s_tdata[2:0]),
        .value   (s_tdata[34:3]),
        .mem_req (mem_req),
        .res     (res)
    );

    rbd_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.is_full, res_reg.is_empty, res_reg.count,
                       res_reg.status, (res_reg.has_data ? rdata : '0)};

    `ASSERT_NEXT(a_accept_valid, aresetn && s_accept, m_tvalid_reg,
                 "accepted word gave no result")
    `ASSERT_NEXT(a_stall_holds, aresetn && m_tvalid_reg && !m_tready, m_tvalid_reg,
                 "pending result dropped while stalled")
    `ASSERT_NEXT(a_data_holds, aresetn && m_tvalid_reg && !m_tready, $stable(m_tdata),
                 "pending result changed while stalled")

endmodule

@@ dv/tb_ring_buffer_deque.sv @@
`timescale 1ns / 1ps
module tb_ring_buffer_deque;
    import rbd_pkg::*;

    // codes the package leaves unnamed; the block treats them as no-ops
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int QUIET_TAIL  = 200;   // last words sent with no idling
    localparam int STALL_LIMIT = 1000;  // cycles with no handshake before giving up
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] value;
    } deque_cmd_t;

    typedef struct {
        logic [31:0]  data;
        rbd_status_t  status;
        logic [10:0]  count;
        logic         is_empty;
        logic         is_full;
    } deque_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;     // [2:0] cmd, [34:3] value, [39:35] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [31:0] data, [33:32] status, [44:34] count,
                                    // [45] is_empty, [46] is_full, [47] zero

    ring_buffer_deque u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    deque_cmd_t    cmd_words[$];
    deque_result_t results_due[$];
    int            n_items   = 0;
    int            n_taken   = 0;
    int            n_errors  = 0;
    int            gen_level = 0;   // occupancy seen by the stimulus generator

    // mirror of the deque
    logic [31:0] mirror [CAPACITY];
    int          mirror_head = 0;
    int          mirror_held = 0;

    task automatic flag_error(input string msg);
        if (n_errors < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic deque_result_t apply_command(input logic [2:0] cmd,
                                                    input logic [31:0] value);
        deque_result_t r;
        logic is_push, is_pop, is_peek, at_front;
        r.data    = '0;
        r.status  = ST_OK;
        is_push   = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
        is_pop    = (cmd == CMD_POP_FRONT)  || (cmd == CMD_POP_BACK);
        is_peek   = (cmd == CMD_PEEK_FRONT) || (cmd == CMD_PEEK_BACK);
        at_front  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_POP_FRONT) ||
                    (cmd == CMD_PEEK_FRONT);
        if (is_push) begin
            if (mirror_held >= CAPACITY) begin
                r.status = ST_FULL;
            end else if (at_front) begin
                mirror_head = (mirror_head + CAPACITY - 1) % CAPACITY;
                mirror[mirror_head] = value;
                mirror_held++;
            end else begin
                mirror[(mirror_head + mirror_held) % CAPACITY] = value;
                mirror_held++;
            end
        end else if (is_pop || is_peek) begin
            if (mirror_held == 0) begin
                r.status = ST_EMPTY;
            end else if (at_front) begin
                r.data = mirror[mirror_head];
                if (is_pop) begin
                    mirror_head = (mirror_head + 1) % CAPACITY;
                    mirror_held--;
                end
            end else begin
                r.data = mirror[(mirror_head + mirror_held - 1) % CAPACITY];
                if (is_pop)
                    mirror_held--;
            end
        end
        r.count    = mirror_held[10:0];
        r.is_empty = (mirror_held == 0);
        r.is_full  = (mirror_held >= CAPACITY);
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(input logic [2:0] cmd, input logic [31:0] value);
        deque_cmd_t w;
        w.cmd   = cmd;
        w.value = value;
        cmd_words.insert(cmd_words.size(), w);
        n_items++;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
            if (gen_level < CAPACITY)
                gen_level++;
        end else if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
            if (gen_level > 0)
                gen_level--;
        end
    endtask

    // push_pct sets the drift of the occupancy; non-push words other than spare codes split pop/peek
    task automatic add_random_word(input int push_pct);
        int r;
        logic front;
        r     = $urandom_range(0, 99);
        front = 1'($urandom_range(0, 1));
        if (r < 2)
            add_word($urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6, pick_value());
        else if (r < push_pct)
            add_word(front ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        else if ($urandom_range(0, 99) < 65)
            add_word(front ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
        else
            add_word(front ? CMD_PEEK_FRONT : CMD_PEEK_BACK, pick_value());
    endtask

    // ---------------- driver
    int s_gap = 0;
    always @(posedge aclk) begin
        deque_cmd_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_words.size() > 0) begin
                w = cmd_words[0];
                cmd_words.delete(0);
                s_tdata  <= {5'b0, w.value, w.cmd};
                s_tvalid <= 1'b1;
                if (cmd_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                    s_gap = $urandom_range(1, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    int m_stall = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (cmd_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                m_stall = $urandom_range(1, 10);
        end
    end

    // ---------------- monitor and checker
    always @(posedge aclk) begin
        deque_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.data     = m_tdata[31:0];
                got.status   = rbd_status_t'(m_tdata[33:32]);
                got.count    = m_tdata[44:34];
                got.is_empty = m_tdata[45];
                got.is_full  = m_tdata[46];
                if (results_due.size() == 0) begin
                    flag_error($sformatf("result word with none due: %h", m_tdata));
                end else begin
                    want = results_due[0];
                    results_due.delete(0);
                    if (got.data !== want.data)
                        flag_error($sformatf("data %h, want %h", got.data, want.data));
                    if (got.status !== want.status)
                        flag_error($sformatf("status %0d, want %0d",
                                             got.status, want.status));
                    if (got.count !== want.count)
                        flag_error($sformatf("count %0d, want %0d", got.count, want.count));
                    if (got.is_empty !== want.is_empty)
                        flag_error($sformatf("is_empty %b, want %b",
                                             got.is_empty, want.is_empty));
                    if (got.is_full !== want.is_full)
                        flag_error($sformatf("is_full %b, want %b",
                                             got.is_full, want.is_full));
                end
            end
            // check before predicting: a result never shares an edge with its command
            if (s_tvalid && s_tready) begin
                results_due.insert(results_due.size(),
                                   apply_command(s_tdata[2:0], s_tdata[34:3]));
                n_taken++;
            end
        end
    end

    // ---------------- watchdog
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL ring_buffer_deque");
                $finish;
            end
        end
    end

    // ---------------- stimulus and end of run
    initial begin
        // empty deque: every read kind errors, spare codes do nothing
        add_word(CMD_PEEK_FRONT, 32'h1234_5678);
        add_word(CMD_PEEK_BACK,  32'h0);
        add_word(CMD_POP_FRONT,  32'hFFFF_FFFF);
        add_word(CMD_POP_BACK,   32'h0);
        add_word(CMD_SPARE_6,    32'hDEAD_BEEF);
        add_word(CMD_SPARE_7,    32'h0);
        // push front from head 0 wraps to the top slot
        add_word(CMD_PUSH_BACK,  32'h7FFF_FFFF);
        add_word(CMD_PUSH_FRONT, 32'h8000_0000);
        add_word(CMD_PUSH_BACK,  32'hFFFF_FFFF);
        add_word(CMD_PUSH_FRONT, 32'h0000_0000);
        add_word(CMD_PEEK_FRONT, 32'h0);
        add_word(CMD_PEEK_BACK,  32'hFFFF_FFFF);
        add_word(CMD_POP_BACK,   32'h0);
        add_word(CMD_POP_FRONT,  32'h0);
        add_word(CMD_POP_FRONT,  32'h0);
        add_word(CMD_POP_BACK,   32'h0);
        add_word(CMD_POP_FRONT,  32'h0);
        add_word(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        add_word(CMD_PUSH_BACK,  32'h5555_5555);
        add_word(CMD_SPARE_7,    32'hFFFF_FFFF);
        add_word(CMD_POP_FRONT,  32'h0);
        add_word(CMD_POP_BACK,   32'h0);

        // random: churn near empty, fill to full, hammer at full, drain partly
        repeat (60) add_random_word(50);
        while (gen_level < CAPACITY) add_random_word(100);
        repeat (30) add_random_word(60);
        repeat (40) add_random_word(10);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(n_taken == n_items && results_due.size() == 0))
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (n_errors == 0)
            $display("PASS ring_buffer_deque");
        else
            $display("FAIL ring_buffer_deque");
        $finish;
    end

endmodule
